// ===== rtl/arctan_series_evaluator_defines.svh =====
// ---------------------------------------------------------------------------
// Arctangent series evaluator: assertion macros
// Shared concurrent assertion forms used by the port checker.
// ---------------------------------------------------------------------------
`ifndef ARCTAN_SERIES_EVALUATOR_DEFINES_SVH
`define ARCTAN_SERIES_EVALUATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ase_pkg.sv =====
// ---------------------------------------------------------------------------
// Arctangent series evaluator package
// Field widths, defaults, register codes and controller/datapath bundles.
// ---------------------------------------------------------------------------
`default_nettype none

package ase_pkg;

    localparam int MAX_TERMS_DEF = 256;
    localparam int FRAC_BITS_DEF = 16;

    localparam int X_W        = 18;
    localparam int CNT_W      = 9;
    localparam int EPS_W      = 16;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 32;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    localparam logic [EPS_W-1:0] EPS_RESET = 16'd16;

    // Word index of the threshold register (byte address bit 2).
    localparam logic REG_EPS = 1'b0;

    typedef struct packed {
        logic load;
        logic div_start;
        logic acc;
        logic mul;
        logic advance;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic stop;
        logic at_cap;
    } sts_t;

endpackage

`default_nettype wire

// ===== rtl/arctan_series_evaluator.sv =====
// ---------------------------------------------------------------------------
// Arctangent series evaluator
// Sums x - x^3/3 + x^5/5 - ... in fixed point until a term drops below the
// programmed threshold or the term cap is reached.
//
//   Channel  Direction  Payload (low bit first)                   Handshake
//   s_*      in         x_value[17:0], zero pad to 24 bits          tvalid/tready
//   m_*      out        arctan_value[17:0], terms_used[8:0],        tvalid/tready
//                       hit_limit, zero pad to 32 bits
//   APB      in/out     eps_threshold at byte address 0              psel/penable
//
// Each term runs one divider start, the bit-serial divide by 2k+1, one
// accumulate and two multiplies by |x|. The input is not ready again
// until the whole item is finished; the single divider takes the bulk
// of each term. One item is worked at a time.
// A finished result waits in the output register while the next beat is taken.
// Reset clears the controller and restores the threshold to 16.
// ---------------------------------------------------------------------------
`default_nettype none

module arctan_series_evaluator #(
    parameter int MAX_TERMS = ase_pkg::MAX_TERMS_DEF,
    parameter int FRAC_BITS = ase_pkg::FRAC_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // [17:0] x_value, [23:18] zero
    input  wire logic [ase_pkg::IN_DATA_W-1:0]     s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [17:0] arctan_value, [26:18] terms_used, [27] hit_limit, [31:28] zero
    output logic [ase_pkg::OUT_DATA_W-1:0]         m_tdata,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [ase_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [ase_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [ase_pkg::APB_DATA_W-1:0]         prdata,
    output logic                                   pready
);

    import ase_pkg::*;

    cmd_t cmd;
    sts_t sts;

    logic [EPS_W-1:0]      eps_reg, eps_next;
    logic                  reg_sel;
    logic signed [X_W-1:0] arctan_value;
    logic [CNT_W-1:0]      terms_used;
    logic                  hit_limit;

    // Byte lanes below the word are ignored; bit 2 selects the register.
    assign reg_sel = (paddr[2] == REG_EPS);

    always_comb
    begin
        eps_next = eps_reg;
        if (psel && penable && pwrite && reg_sel)
            eps_next = pwdata[EPS_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_reg <= EPS_RESET;
        end
        else
        begin
            eps_reg <= eps_next;
        end
    end

    assign pready = 1'b1;
    assign prdata = reg_sel ? APB_DATA_W'(eps_reg) : '0;

    ase_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    ase_dpath #(
        .MAX_TERMS (MAX_TERMS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .x_value       ($signed(s_tdata[X_W-1:0])),
        .eps_threshold (eps_reg),
        .arctan_value  (arctan_value),
        .terms_used    (terms_used),
        .hit_limit     (hit_limit)
    );

    assign m_tdata = OUT_DATA_W'({hit_limit, terms_used, arctan_value});

endmodule

`default_nettype wire

// ===== rtl/ase_div.sv =====
// ---------------------------------------------------------------------------
// Arctangent series evaluator: restoring divider
// Unsigned divide, one quotient bit per cycle, quotient MSB first.
// ---------------------------------------------------------------------------
`default_nettype none

module ase_div #(
    parameter int PW = 17,
    parameter int DW = 9
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [PW-1:0] dividend,
    input  wire logic [DW-1:0] divisor,
    output logic      [PW-1:0] quotient,
    output logic               done
);

    localparam int CW = $clog2(PW + 1);

    logic [PW-1:0] quo_reg, quo_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [DW:0]   trial;
    logic [DW:0]   diff;

    assign trial = {rem_reg, quo_reg[PW-1]};
    assign diff  = trial - {1'b0, divisor};

    always_comb
    begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        if (start)
        begin
            quo_next = dividend;
            rem_next = '0;
            cnt_next = CW'(PW);
        end
        else if (cnt_reg != '0)
        begin
            // The remainder stays below the divisor, so the trial fits DW+1 bits.
            if (trial >= {1'b0, divisor})
            begin
                rem_next = diff[DW-1:0];
                quo_next = {quo_reg[PW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DW-1:0];
                quo_next = {quo_reg[PW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign quotient = quo_reg;
    assign done     = (cnt_reg == '0);

endmodule

`default_nettype wire

// ===== rtl/ase_dpath.sv =====
// ---------------------------------------------------------------------------
// Arctangent series evaluator: datapath
// Power register, shared multiplier, divider, signed accumulator, result.
// ---------------------------------------------------------------------------
`default_nettype none

module ase_dpath #(
    parameter int MAX_TERMS = ase_pkg::MAX_TERMS_DEF,
    parameter int FRAC_BITS = ase_pkg::FRAC_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire ase_pkg::cmd_t                 cmd,
    output ase_pkg::sts_t                      sts,
    input  wire logic signed [ase_pkg::X_W-1:0] x_value,
    input  wire logic [ase_pkg::EPS_W-1:0]     eps_threshold,
    output logic signed [ase_pkg::X_W-1:0]     arctan_value,
    output logic [ase_pkg::CNT_W-1:0]          terms_used,
    output logic                               hit_limit
);

    import ase_pkg::*;

    localparam int PW = FRAC_BITS + 1;
    localparam int SW = FRAC_BITS + 2;
    localparam int NW = $clog2(MAX_TERMS);
    localparam int DW = NW + 1;
    localparam int EW = (X_W > SW) ? X_W : SW;
    localparam int SAT_HI = (1 << (X_W - 1)) - 1;
    localparam int SAT_LO = -(1 << (X_W - 1));
    localparam int CNT_MAX = (1 << CNT_W) - 1;

    logic                 neg_reg, neg_next;
    logic [PW-1:0]        m_reg, m_next;
    logic [PW-1:0]        pm_reg, pm_next;
    logic [NW-1:0]        n_reg, n_next;
    logic [DW-1:0]        odd_reg, odd_next;
    logic signed [SW-1:0] sum_reg, sum_next;
    logic                 hit_reg, hit_next;

    logic signed [X_W-1:0] arctan_reg;
    logic [CNT_W-1:0]      terms_reg;
    logic                  hit_out_reg;

    logic signed [EW-1:0] x_ext;
    logic signed [EW-1:0] x_sat;
    logic signed [EW-1:0] x_abs;
    logic signed [EW-1:0] one_ext;
    logic [2*PW-1:0]      prod;
    logic [PW-1:0]        quo;
    logic                 div_done;
    logic [FRAC_BITS-1:0] eps_sc;
    logic signed [SW-1:0] term_s;
    logic                 term_neg;
    logic [NW:0]          cnt_full;
    logic signed [X_W-1:0] sum_sat;
    logic [CNT_W-1:0]     cnt_sat;

    ase_div #(
        .PW (PW),
        .DW (DW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (pm_reg),
        .divisor  (odd_reg),
        .quotient (quo),
        .done     (div_done)
    );

    // Saturate x to [-1.0, +1.0] and split it into sign and magnitude.
    assign one_ext = EW'(1) << FRAC_BITS;
    assign x_ext   = EW'(x_value);

    always_comb
    begin
        if (x_ext > one_ext)
            x_sat = one_ext;
        else if (x_ext < -one_ext)
            x_sat = -one_ext;
        else
            x_sat = x_ext;
        x_abs = (x_sat < 0) ? -x_sat : x_sat;
    end

    generate
        if (FRAC_BITS >= EPS_W)
        begin : g_eps_up
            assign eps_sc = FRAC_BITS'(eps_threshold) << (FRAC_BITS - EPS_W);
        end
        else
        begin : g_eps_down
            assign eps_sc = FRAC_BITS'(eps_threshold >> (EPS_W - FRAC_BITS));
        end
    endgenerate

    assign prod     = pm_reg * m_reg;
    assign term_s   = $signed({1'b0, quo});
    assign term_neg = neg_reg ^ n_reg[0];

    always_comb
    begin
        neg_next = neg_reg;
        m_next   = m_reg;
        pm_next  = pm_reg;
        n_next   = n_reg;
        odd_next = odd_reg;
        sum_next = sum_reg;
        hit_next = hit_reg;
        if (cmd.load)
        begin
            neg_next = x_sat < 0;
            m_next   = x_abs[PW-1:0];
            pm_next  = x_abs[PW-1:0];
            n_next   = '0;
            odd_next = DW'(1);
            sum_next = '0;
        end
        if (cmd.acc)
        begin
            sum_next = term_neg ? (sum_reg - term_s) : (sum_reg + term_s);
            hit_next = ~sts.stop;
        end
        if (cmd.mul)
        begin
            pm_next = prod[FRAC_BITS +: PW];
        end
        if (cmd.advance)
        begin
            n_next   = n_reg + 1'b1;
            odd_next = odd_reg + DW'(2);
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        m_reg   <= m_next;
        pm_reg  <= pm_next;
        n_reg   <= n_next;
        odd_reg <= odd_next;
        sum_reg <= sum_next;
        hit_reg <= hit_next;
    end

    assign cnt_full = {1'b0, n_reg} + 1'b1;

    generate
        if (SW > X_W)
        begin : g_sum_clamp
            always_comb
            begin
                if (sum_reg > $signed(SW'(SAT_HI)))
                    sum_sat = X_W'(SAT_HI);
                else if (sum_reg < $signed(SW'(SAT_LO)))
                    sum_sat = X_W'(SAT_LO);
                else
                    sum_sat = X_W'(sum_reg);
            end
        end
        else
        begin : g_sum_ext
            assign sum_sat = X_W'(sum_reg);
        end

        if (NW + 1 > CNT_W)
        begin : g_cnt_clamp
            assign cnt_sat = (cnt_full > (NW + 1)'(CNT_MAX)) ? CNT_W'(CNT_MAX)
                                                            : CNT_W'(cnt_full);
        end
        else
        begin : g_cnt_ext
            assign cnt_sat = CNT_W'(cnt_full);
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            arctan_reg  <= sum_sat;
            terms_reg   <= cnt_sat;
            hit_out_reg <= hit_reg;
        end
    end

    assign sts.div_done = div_done;
    assign sts.stop     = quo < {1'b0, eps_sc};
    assign sts.at_cap   = (n_reg == NW'(MAX_TERMS - 1));

    assign arctan_value = arctan_reg;
    assign terms_used   = terms_reg;
    assign hit_limit    = hit_out_reg;

endmodule

`default_nettype wire

// ===== rtl/ase_ctrl.sv =====
// ---------------------------------------------------------------------------
// Arctangent series evaluator: controller
// Loads an item, then sequences divide, accumulate and two multiplies per series term.
// ---------------------------------------------------------------------------
`default_nettype none

module ase_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output ase_pkg::cmd_t      cmd,
    input  wire ase_pkg::sts_t sts
);

    import ase_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_START = 7'b0000010,
        ST_DIV   = 7'b0000100,
        ST_ACC   = 7'b0001000,
        ST_MUL1  = 7'b0010000,
        ST_MUL2  = 7'b0100000,
        ST_DONE  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV:
            begin
                if (sts.div_done)
                    state_next = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.acc = 1'b1;
                if (sts.stop || sts.at_cap)
                    state_next = ST_DONE;
                else
                    state_next = ST_MUL1;
            end
            ST_MUL1:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                cmd.mul     = 1'b1;
                cmd.advance = 1'b1;
                state_next  = ST_START;
            end
            ST_DONE:
            begin
                // The result register frees up in the same cycle its beat is taken.
                if (!m_tvalid_reg || m_tready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.out_load)
            m_tvalid_next = 1'b1;
        else if (m_tready)
            m_tvalid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

endmodule

`default_nettype wire

// ===== rtl/ase_checker.sv =====
// ---------------------------------------------------------------------------
// Arctangent series evaluator: port checker
// Watches the stream ports for handshake and result consistency.
// ---------------------------------------------------------------------------
`default_nettype none

`include "arctan_series_evaluator_defines.svh"

module ase_checker #(
    parameter int MAX_TERMS = ase_pkg::MAX_TERMS_DEF
) (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [ase_pkg::OUT_DATA_W-1:0] m_tdata
);

    import ase_pkg::*;

    localparam int CNT_MAX = (1 << CNT_W) - 1;
    localparam int CAP = (MAX_TERMS > CNT_MAX) ? CNT_MAX : MAX_TERMS;

    logic [CNT_W-1:0] terms_seen;
    logic             hit_seen;

    assign terms_seen = m_tdata[X_W +: CNT_W];
    assign hit_seen   = m_tdata[X_W + CNT_W];

    `ASE_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata), "result beat changed while stalled")

    `ASE_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, s_tvalid && s_tready,
        !s_tready, "input accepted while an item is in progress")

    `ASE_ASSERT_NOW(a_terms_nonzero, clk, rst_n, m_tvalid,
        terms_seen != '0, "result reports zero terms")

    `ASE_ASSERT_NOW(a_limit_count, clk, rst_n, m_tvalid && hit_seen,
        terms_seen == CNT_W'(CAP), "limit flag without a full term count")

endmodule

bind arctan_series_evaluator ase_checker #(.MAX_TERMS(MAX_TERMS)) u_ase_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
